// File: design/iqp_pkg.sv
package iqp_pkg;

    localparam int SAMPLE_W        = 18;
    localparam int GAIN_W          = 16;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int CORDIC_MAX_STAGES = 32;
    localparam int GUARD_BITS      = 8;

    // Vector width covers the 2^25 start magnitude times the CORDIC growth.
    localparam int X_W = 29;
    // Angle in units of pi, 30 fraction bits, start of +-1 plus the atan sum.
    localparam int Z_W = 32;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 18'sd131071;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -18'sd131072;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RUN_ENABLE = 2'd0,
        CFG_MAG_GAIN   = 2'd1,
        CFG_PHASE_GAIN = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic signed [X_W-1:0]      x;
        logic signed [X_W-1:0]      y;
        logic signed [Z_W-1:0]      z;
        logic                       zero;
        logic signed [SAMPLE_W-1:0] i_raw;
        logic signed [SAMPLE_W-1:0] q_raw;
        logic                       block_end;
    } t_cordic_stage;

    // atan(2^-i) / pi in Q2.30, rounded.
    function automatic logic signed [Z_W-1:0] atan_pi(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd268435456;
            5'd1:  v = 32'sd158466703;
            5'd2:  v = 32'sd83729454;
            5'd3:  v = 32'sd42502378;
            5'd4:  v = 32'sd21333666;
            5'd5:  v = 32'sd10677233;
            5'd6:  v = 32'sd5339919;
            5'd7:  v = 32'sd2670123;
            5'd8:  v = 32'sd1335082;
            5'd9:  v = 32'sd667543;
            5'd10: v = 32'sd333772;
            5'd11: v = 32'sd166886;
            5'd12: v = 32'sd83443;
            5'd13: v = 32'sd41722;
            5'd14: v = 32'sd20861;
            5'd15: v = 32'sd10430;
            5'd16: v = 32'sd5215;
            5'd17: v = 32'sd2608;
            5'd18: v = 32'sd1304;
            5'd19: v = 32'sd652;
            5'd20: v = 32'sd326;
            5'd21: v = 32'sd163;
            5'd22: v = 32'sd81;
            5'd23: v = 32'sd41;
            5'd24: v = 32'sd20;
            5'd25: v = 32'sd10;
            5'd26: v = 32'sd5;
            5'd27: v = 32'sd3;
            5'd28: v = 32'sd1;
            5'd29: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat18(input logic signed [31:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 32'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < 32'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/iq_to_polar_scaler.sv
// Path from an accepted request to o_out_valid: one entry register, one
// register per CORDIC iteration, four multiply/round stages and the output
// register.
// Throughput: one request per clock; a stall freezes the whole pipeline.
// Reset (synchronous, active low) empties all stages and loads run_enable = 0,
// mag_gain = phase_gain = 1.0.
module iq_to_polar_scaler #(
    parameter int CORDIC_STAGES = iqp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [iqp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [iqp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // input request
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_i_sample,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_q_sample,
    input  logic                                 i_block_end,
    // result request
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [iqp_pkg::SAMPLE_W-1:0]  o_first_out,
    output logic signed [iqp_pkg::SAMPLE_W-1:0]  o_second_out,
    output logic                                 o_block_end_out
);
    import iqp_pkg::*;

    // More than the table holds behaves as a full table.
    localparam int NumIter = (CORDIC_STAGES > CORDIC_MAX_STAGES) ?
                             CORDIC_MAX_STAGES : CORDIC_STAGES;

    localparam int PX_W = X_W + 32;        // x times 1/K (Q1.31)
    localparam int PZ_W = Z_W + GAIN_W;    // z times phase gain
    localparam int M_W  = PX_W - 39;       // magnitude after dropping 31+8 bits
    localparam int PM_W = M_W + GAIN_W + 1;
    localparam int F_W  = PM_W - 12;
    localparam int S_W  = PZ_W - 25;

    localparam logic signed [31:0]     INV_K   = 32'sd1304065748;
    localparam logic signed [PX_W-1:0] RND_MAG = PX_W'(64'sd1 <<< 38);
    localparam logic signed [PZ_W-1:0] RND_PH  = PZ_W'(64'sd1 <<< 24);
    localparam logic signed [PM_W-1:0] RND_G   = PM_W'(64'sd1 <<< 11);
    localparam logic signed [Z_W-1:0]  Z_PI    = Z_W'(64'sd1 <<< 30);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                     r_run_enable;
    logic [GAIN_W-1:0]        r_mag_gain;
    logic signed [GAIN_W-1:0] r_phase_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b0;
            r_mag_gain   <= GAIN_W'(4096);
            r_phase_gain <= GAIN_W'(4096);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_RUN_ENABLE: r_run_enable <= i_cfg_wdata[0];
                CFG_MAG_GAIN:   r_mag_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_PHASE_GAIN: r_phase_gain <= i_cfg_wdata[GAIN_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the skid register
    // holds a result. The skid flag is a register, so the enable never
    // depends combinationally on i_out_ready.
    // ---------------------------------------------------------------
    logic r_skid_v;
    logic w_en;
    logic w_in_acc;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;
    assign w_in_acc   = i_in_valid && w_en;

    // ---------------------------------------------------------------
    // Entry stage: scale up by the guard bits, fold the left half plane
    // onto the right one and preload the angle with +-pi.
    // ---------------------------------------------------------------
    logic signed [X_W-1:0] w_xi;
    logic signed [X_W-1:0] w_yq;
    t_cordic_stage         n_entry;

    always_comb begin
        w_xi = X_W'(i_i_sample) <<< GUARD_BITS;
        w_yq = X_W'(i_q_sample) <<< GUARD_BITS;
        n_entry.zero      = (i_i_sample == '0) && (i_q_sample == '0);
        n_entry.i_raw     = i_i_sample;
        n_entry.q_raw     = i_q_sample;
        n_entry.block_end = i_block_end;
        if (i_i_sample < 0) begin
            n_entry.x = -w_xi;
            n_entry.y = -w_yq;
            n_entry.z = (i_q_sample >= 0) ? Z_PI : -Z_PI;
        end else begin
            n_entry.x = w_xi;
            n_entry.y = w_yq;
            n_entry.z = '0;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC vectoring: one iteration per register stage. Stage 0 is the
    // entry register, stage s+1 holds the result of iteration s.
    // ---------------------------------------------------------------
    t_cordic_stage      r_cs [0:NumIter];
    t_cordic_stage      n_cs [1:NumIter];
    logic [NumIter:0]   r_cv;

    for (genvar s = 0; s < NumIter; s++) begin : g_iter
        logic signed [X_W-1:0] w_xs;
        logic signed [X_W-1:0] w_ys;

        always_comb begin
            w_xs = r_cs[s].x >>> s;
            w_ys = r_cs[s].y >>> s;
            n_cs[s+1] = r_cs[s];
            // rotate toward the x axis; old x and y feed both updates
            if (r_cs[s].y < 0) begin
                n_cs[s+1].x = r_cs[s].x - w_ys;
                n_cs[s+1].y = r_cs[s].y + w_xs;
                n_cs[s+1].z = r_cs[s].z - atan_pi(5'(s));
            end else begin
                n_cs[s+1].x = r_cs[s].x + w_ys;
                n_cs[s+1].y = r_cs[s].y - w_xs;
                n_cs[s+1].z = r_cs[s].z + atan_pi(5'(s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs[0] <= n_entry;
            for (int k = 1; k <= NumIter; k++) begin
                r_cs[k] <= n_cs[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Post-processing stages
    //   m1: x * 1/K and z * phase gain
    //   m2: round magnitude; round and saturate phase
    //   m3: magnitude * mag gain
    //   m4: round and saturate magnitude; pick zero, polar or bypass data
    // ---------------------------------------------------------------
    logic r_m1_v, r_m2_v, r_m3_v, r_t_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= '0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_t_v  <= 1'b0;
        end else if (w_en) begin
            r_cv   <= {r_cv[NumIter-1:0], w_in_acc};
            r_m1_v <= r_cv[NumIter];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_t_v  <= r_m3_v;
        end
    end

    // side data that rides along with each stage
    typedef struct packed {
        logic                       zero;
        logic signed [SAMPLE_W-1:0] i_raw;
        logic signed [SAMPLE_W-1:0] q_raw;
        logic                       block_end;
    } t_side;

    t_side                      r_m1_sd, r_m2_sd, r_m3_sd;
    logic signed [PX_W-1:0]     r_m1_px;
    logic signed [PZ_W-1:0]     r_m1_pz;
    logic signed [M_W-1:0]      r_m2_mag;
    logic signed [SAMPLE_W-1:0] r_m2_sec, r_m3_sec;
    logic signed [PM_W-1:0]     r_m3_pm;
    logic signed [SAMPLE_W-1:0] r_t_first, r_t_second;
    logic                       r_t_be;

    logic signed [PX_W-1:0]     n_m1_px;
    logic signed [PZ_W-1:0]     n_m1_pz;
    logic signed [M_W-1:0]      n_m2_mag;
    logic signed [S_W-1:0]      w_sec_full;
    logic signed [PM_W-1:0]     n_m3_pm;
    logic signed [F_W-1:0]      w_first_full;
    logic signed [SAMPLE_W-1:0] n_t_first, n_t_second;

    always_comb begin
        n_m1_px      = r_cs[NumIter].x * INV_K;
        n_m1_pz      = r_cs[NumIter].z * r_phase_gain;
        n_m2_mag     = M_W'((r_m1_px + RND_MAG) >>> 39);
        w_sec_full   = S_W'((r_m1_pz + RND_PH) >>> 25);
        n_m3_pm      = r_m2_mag * $signed({1'b0, r_mag_gain});
        w_first_full = F_W'((r_m3_pm + RND_G) >>> 12);

        // the user changes configuration only while idle; not enforced here
        if (!r_run_enable) begin
            n_t_first  = r_m3_sd.i_raw;
            n_t_second = r_m3_sd.q_raw;
        end else if (r_m3_sd.zero) begin
            n_t_first  = '0;
            n_t_second = '0;
        end else begin
            n_t_first  = sat18(32'(w_first_full));
            n_t_second = r_m3_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_px    <= n_m1_px;
            r_m1_pz    <= n_m1_pz;
            r_m1_sd    <= '{zero: r_cs[NumIter].zero, i_raw: r_cs[NumIter].i_raw,
                            q_raw: r_cs[NumIter].q_raw,
                            block_end: r_cs[NumIter].block_end};
            r_m2_mag   <= n_m2_mag;
            r_m2_sec   <= sat18(32'(w_sec_full));
            r_m2_sd    <= r_m1_sd;
            r_m3_pm    <= n_m3_pm;
            r_m3_sec   <= r_m2_sec;
            r_m3_sd    <= r_m2_sd;
            r_t_first  <= n_t_first;
            r_t_second <= n_t_second;
            r_t_be     <= r_m3_sd.block_end;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid register. A result that leaves the pipeline
    // while the output is held parks in the skid and stalls the pipeline.
    // ---------------------------------------------------------------
    logic                       r_out_v;
    logic signed [SAMPLE_W-1:0] r_out_first, r_out_second, r_skid_first, r_skid_second;
    logic                       r_out_be, r_skid_be;
    logic                       w_out_load;

    assign w_out_load = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_skid_v <= 1'b0;  // output stays valid with the skid entry
            end
        end else if (w_out_load) begin
            r_out_v <= r_t_v;
        end else if (r_t_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_first  <= r_skid_first;
                r_out_second <= r_skid_second;
                r_out_be     <= r_skid_be;
            end
        end else if (w_out_load) begin
            r_out_first  <= r_t_first;
            r_out_second <= r_t_second;
            r_out_be     <= r_t_be;
        end else begin
            r_skid_first  <= r_t_first;
            r_skid_second <= r_t_second;
            r_skid_be     <= r_t_be;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_first_out     = r_out_first;
    assign o_second_out    = r_out_second;
    assign o_block_end_out = r_out_be;

endmodule

// File: dv/polar_result_checker.sv
`timescale 1ns / 100ps

module polar_result_checker #(
    parameter int STAGES = iqp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [iqp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [iqp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_i_sample,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_q_sample,
    input  logic                                 i_block_end,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_first_out,
    input  logic signed [iqp_pkg::SAMPLE_W-1:0]  i_second_out,
    input  logic                                 i_block_end_out,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    import iqp_pkg::*;

    localparam int     MAX_PRINTED = 40;
    localparam longint INV_K_Q31   = 64'sd1304065748;

    // atan(2^-i) / pi with 30 fraction bits
    localparam longint ATAN_PI_Q30 [32] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
        5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0, 0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first;
        logic signed [SAMPLE_W-1:0] second;
        logic                       block_end;
    } t_polar_result;

    logic                      run_enable;
    logic [GAIN_W-1:0]         mag_gain;
    logic signed [GAIN_W-1:0]  phase_gain;
    t_polar_result             expected_polar_q [$];
    int                        fail_total;
    int                        result_index;

    assign o_fail_count = fail_total;

    initial begin
        fail_total   = 0;
        result_index = 0;
        run_enable   = 1'b0;
        mag_gain     = 16'd4096;
        phase_gain   = 16'sd4096;
    end

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > longint'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < longint'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Vectoring rotation on the guarded vector, then gain and round.
    function automatic t_polar_result predict_polar(input logic signed [SAMPLE_W-1:0] i_s,
                                                    input logic signed [SAMPLE_W-1:0] q_s,
                                                    input logic be);
        t_polar_result r;
        longint x, y, z, xs, ys, mag;
        int n;
        r.block_end = be;
        r.first     = i_s;
        r.second    = q_s;
        if (run_enable && (i_s != 0 || q_s != 0)) begin
            x = longint'(i_s) * 256;
            y = longint'(q_s) * 256;
            z = 0;
            if (i_s < 0) begin
                x = -x;
                y = -y;
                z = (q_s >= 0) ? (longint'(1) << 30) : -(longint'(1) << 30);
            end
            n = (STAGES > 32) ? 32 : STAGES;
            for (int s = 0; s < n; s++) begin
                xs = x >>> s;
                ys = y >>> s;
                if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_PI_Q30[s];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_PI_Q30[s];
                end
            end
            mag = (x * INV_K_Q31 + (longint'(1) << 38)) >>> 39;
            r.first  = clamp_sample((mag * longint'(mag_gain) + 2048) >>> 12);
            r.second = clamp_sample((z * longint'(phase_gain) + (longint'(1) << 24)) >>> 25);
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        fail_total++;
        if (fail_total <= MAX_PRINTED) begin
            $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_polar_result want;
        if (!i_rst_n) begin
            expected_polar_q.delete();
            run_enable = 1'b0;
            mag_gain   = 16'd4096;
            phase_gain = 16'sd4096;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_RUN_ENABLE: run_enable = i_cfg_wdata[0];
                    CFG_MAG_GAIN:   mag_gain   = i_cfg_wdata;
                    CFG_PHASE_GAIN: phase_gain = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_polar_q.push_back(predict_polar(i_i_sample, i_q_sample, i_block_end));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_polar_q.size() == 0) begin
                    report_failure($sformatf("unexpected result first=%0d second=%0d",
                                             i_first_out, i_second_out));
                end else begin
                    want = expected_polar_q.pop_front();
                    if (i_first_out !== want.first) begin
                        report_failure($sformatf("first_out %0d, want %0d",
                                                 i_first_out, want.first));
                    end
                    if (i_second_out !== want.second) begin
                        report_failure($sformatf("second_out %0d, want %0d",
                                                 i_second_out, want.second));
                    end
                    if (i_block_end_out !== want.block_end) begin
                        report_failure($sformatf("block_end_out %0b, want %0b",
                                                 i_block_end_out, want.block_end));
                    end
                end
                result_index++;
            end
        end
        o_pending <= expected_polar_q.size();
    end

endmodule

// File: dv/iq_to_polar_scaler_tb.sv
`timescale 1ns / 100ps

module iq_to_polar_scaler_tb;

    import iqp_pkg::*;

    // Entry register, one register per CORDIC stage, four arithmetic stages
    // and the output register.
    localparam int PIPE_LATENCY    = CORDIC_STAGES_DEF + 5;
    // Longest correct quiet stretch is the long receiver hold-off.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 133;
    localparam int HOLD_OFF_CYCLES = 300;
    // Address with no register behind it; writes there must be dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_ADDR = 2'd3;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata     = '0;
    logic                        i_in_valid      = 1'b0;
    logic signed [SAMPLE_W-1:0]  i_i_sample      = '0;
    logic signed [SAMPLE_W-1:0]  i_q_sample      = '0;
    logic                        i_block_end     = 1'b0;
    logic                        i_out_ready     = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [SAMPLE_W-1:0]  o_first_out;
    logic signed [SAMPLE_W-1:0]  o_second_out;
    logic                        o_block_end_out;

    int fail_count;
    int pending;
    int hold_off_len = 0;   // set by the stimulus, served by the receiver
    int burst_left   = 0;
    int quiet_cycles = 0;

    iq_to_polar_scaler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_i_sample      (i_i_sample),
        .i_q_sample      (i_q_sample),
        .i_block_end     (i_block_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_first_out     (o_first_out),
        .o_second_out    (o_second_out),
        .o_block_end_out (o_block_end_out)
    );

    polar_result_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_i_sample      (i_i_sample),
        .i_q_sample      (i_q_sample),
        .i_block_end     (i_block_end),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_first_out     (o_first_out),
        .i_second_out    (o_second_out),
        .i_block_end_out (o_block_end_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: switch between random stall patterns; serve a long hold-off
    // when the stimulus asks for one, counting it here.
    initial begin
        int rx_mode;
        int rx_cycle;
        rx_mode  = 0;
        rx_cycle = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end else begin
                if (rx_cycle % 128 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                end
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= (rx_cycle % 7 < 4);
                    default: i_out_ready <= 1'($urandom_range(0, 1));
                endcase
                rx_cycle++;
            end
        end
    end

    // Write one register; drop the enable on the next edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program every register, plus a stray write to the unused address.
    task automatic set_config(input logic en, input logic [GAIN_W-1:0] mag,
                              input logic [GAIN_W-1:0] ph);
        write_reg(CFG_RUN_ENABLE, {15'($urandom()), en});
        write_reg(CFG_MAG_GAIN, mag);
        write_reg(CFG_PHASE_GAIN, ph);
        write_reg(CFG_SPARE_ADDR, 16'($urandom()));
    endtask

    // Offer one request and hold it until accepted. Between bursts, drop
    // valid for a random gap; long bursts give stretches with no idling.
    task automatic send_request(input logic signed [SAMPLE_W-1:0] i_val,
                                input logic signed [SAMPLE_W-1:0] q_val,
                                input logic be);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_i_sample  <= i_val;
        i_q_sample  <= q_val;
        i_block_end <= be;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
            1: v = '0;
            2: begin
                v = SAMPLE_W'($urandom_range(0, 16));
                v = v - 18'sd8;
            end
            default: v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    // Gains: half full range, half near unity so results do not all clip.
    function automatic logic [GAIN_W-1:0] pick_mag_gain();
        return $urandom_range(0, 1) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(0, 8192));
    endfunction

    function automatic logic [GAIN_W-1:0] pick_phase_gain();
        logic signed [GAIN_W-1:0] g;
        if ($urandom_range(0, 1)) begin
            g = GAIN_W'($urandom());
        end else begin
            g = GAIN_W'($urandom_range(0, 16384));
            g = g - 16'sd8192;
        end
        return g;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pass-through at reset settings: field extremes both ways.
        send_request(SAT_MAX, SAT_MIN, 1'b1);
        send_request(SAT_MIN, SAT_MAX, 1'b0);
        send_request(18'sd0, -18'sd1, 1'b1);
        drain_results();

        // Conversion at unity gains: zero vector, axes, corners, negative real axis.
        write_reg(CFG_RUN_ENABLE, 16'd1);
        send_request(18'sd0, 18'sd0, 1'b0);
        send_request(SAT_MIN, 18'sd0, 1'b1);
        send_request(-18'sd1, 18'sd0, 1'b0);
        send_request(SAT_MAX, 18'sd0, 1'b0);
        send_request(18'sd0, SAT_MAX, 1'b1);
        send_request(18'sd0, SAT_MIN, 1'b0);
        send_request(SAT_MIN, SAT_MIN, 1'b0);
        send_request(SAT_MAX, SAT_MAX, 1'b1);
        send_request(SAT_MIN, SAT_MAX, 1'b0);
        send_request(SAT_MAX, SAT_MIN, 1'b1);
        send_request(18'sd1, 18'sd0, 1'b0);
        send_request(-18'sd1, -18'sd1, 1'b0);
        send_request(18'sd0, -18'sd1, 1'b1);
        send_request(-18'sd1, 18'sd1, 1'b0);
        send_request(18'sd1000, -18'sd1000, 1'b1);
        send_request(-18'sd65536, 18'sd1, 1'b0);
        drain_results();

        // Random phases: unity, extreme and bypass settings first, then random settings.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_config(1'b1, 16'd4096, 16'd4096);
                1: set_config(1'b1, 16'hFFFF, 16'h7FFF);
                2: set_config(1'b1, 16'd0, 16'h8000);
                3: set_config(1'b0, pick_mag_gain(), pick_phase_gain());
                4: set_config(1'b1, 16'd1, 16'hFFFF);
                default: set_config($urandom_range(0, 4) != 0, pick_mag_gain(),
                                    pick_phase_gain());
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Hold the receiver off while requests keep coming, so the
                // pipeline fills and back-pressures the input.
                if (phase == 2 && k == 20) begin
                    hold_off_len = HOLD_OFF_CYCLES;
                end
                send_request(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
            end
            drain_results();
        end

        // Let any stray result surface before the verdict.
        repeat (PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
